@@ hdl/slc_pkg.sv @@
// Package for the source line classifier: line class codes, register
// indexes, byte constants and marker helpers. No dependencies.
`default_nettype none

package slc_pkg;

    // Line classes as carried on the result channel
    typedef enum logic [1:0] {
        CLS_CODE   = 2'd0,
        CLS_BLANK  = 2'd1,
        CLS_SINGLE = 2'd2,
        CLS_BLOCK  = 2'd3
    } line_class_t;

    localparam int CFG_IDX_BITS = 3;
    localparam int MARKER_BITS  = 32;
    localparam int LEN_BITS     = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_MARKER = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_LEN    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_MARKER   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_LEN      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_MARKER  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_LEN     = 3'd5;

    // Reset values of the configuration registers
    localparam logic [MARKER_BITS-1:0] SINGLE_MARKER_RST = 32'h0000_2F2F;
    localparam logic [MARKER_BITS-1:0] OPEN_MARKER_RST   = 32'h0000_2A2F;
    localparam logic [MARKER_BITS-1:0] CLOSE_MARKER_RST  = 32'h0000_2F2A;
    localparam logic [LEN_BITS-1:0]    SINGLE_LEN_RST    = 3'd2;
    localparam logic [LEN_BITS-1:0]    OPEN_LEN_RST      = 3'd2;
    localparam logic [LEN_BITS-1:0]    CLOSE_LEN_RST     = 3'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;

    localparam int MARKER_BYTES_DEF = 4;
    localparam int COUNT_BITS_DEF   = 32;

    // Byte idx of a marker, first byte lowest; bytes past the register are zero
    function automatic logic [7:0] marker_byte(input logic [MARKER_BITS-1:0] marker,
                                               input int idx);
        logic [7:0] b;
        b = 8'd0;
        if (idx >= 0 && idx < MARKER_BITS / 8) begin
            b = marker[8*idx +: 8];
        end
        return b;
    endfunction

    // Length clipped to the number of marker bytes the design keeps
    function automatic int eff_len(input logic [LEN_BITS-1:0] len, input int max_bytes);
        int l;
        l = int'(len);
        if (l > max_bytes) begin
            l = max_bytes;
        end
        return l;
    endfunction

endpackage

`default_nettype wire

@@ hdl/source_line_classifier_core.sv @@
// Source line classifier core: classifies text lines byte by byte and
// keeps saturating code and non-code line counts. Depends on slc_pkg.
//
// Usage: bytes of a text file enter on the s_ channel (s_ch, with
// s_last_in_file marking the final byte of a file). One result item leaves
// on the m_ channel for every finished line: a line ends at byte 10 or at
// the final byte of a file. Bytes that do not end a line give no result.
// The cfg channel writes the marker and length registers (index, data); it is
// always ready and is to be used only while the block is idle; it does not check it.
// Timing: an accepted byte is held in the input register, then classified;
// a line-ending byte's result goes to the output register, which drives m_.
// Throughput: one byte per cycle unless a line-ending byte stalls; per-line
// state is updated by a single compare pass over input and state registers.
// Stall: while m_ready is low and a result waits, bytes that end no line
// keep flowing; a line-ending byte waits in the input register, and
// s_ready falls only then.
// Reset (aresetn low, synchronous): markers return to "//", "/*", "*/",
// block mode and both counters clear, both channels empty.
`default_nettype none

module source_line_classifier_core
    import slc_pkg::*;
#(
    parameter int MARKER_BYTES = MARKER_BYTES_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [MARKER_BITS-1:0]  cfg_data,
    // Byte input
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_ch,
    input  wire logic                    s_last_in_file,
    // Line results
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_line_class,
    output logic [31:0]                  m_code_lines,
    output logic [31:0]                  m_other_lines,
    output logic                         m_file_done
);

    localparam int PW = $clog2(MARKER_BYTES + 1);
    localparam int TW = 8 * MARKER_BYTES;

    // Configuration registers
    logic [MARKER_BITS-1:0] single_marker_reg, open_marker_reg, close_marker_reg;
    logic [LEN_BITS-1:0]    single_len_reg, open_len_reg, close_len_reg;

    // Input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;

    // Line state
    logic                  in_block_reg, in_block_next;
    logic                  started_reg, started_next;
    logic                  nonblank_reg, nonblank_next;
    logic [PW-1:0]         prefix_pos_reg, prefix_pos_next;
    logic                  single_match_reg, single_match_next;
    logic                  open_match_reg, open_match_next;
    logic [TW-1:0]         tail_reg, tail_next;
    logic [PW-1:0]         search_count_reg, search_count_next;
    logic                  close_seen_reg, close_seen_next;
    logic [COUNT_BITS-1:0] code_count_reg, code_count_next;
    logic [COUNT_BITS-1:0] other_count_reg, other_count_next;

    // Output register
    logic        out_valid_reg;
    line_class_t out_class_reg;
    logic        out_done_reg;
    logic [31:0] out_code_reg;
    logic [31:0] out_other_reg;
    line_class_t cls_next;

    logic emit;
    logic advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            single_marker_reg <= SINGLE_MARKER_RST;
            single_len_reg    <= SINGLE_LEN_RST;
            open_marker_reg   <= OPEN_MARKER_RST;
            open_len_reg      <= OPEN_LEN_RST;
            close_marker_reg  <= CLOSE_MARKER_RST;
            close_len_reg     <= CLOSE_LEN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SINGLE_MARKER: single_marker_reg <= cfg_data;
                REG_SINGLE_LEN:    single_len_reg    <= cfg_data[LEN_BITS-1:0];
                REG_OPEN_MARKER:   open_marker_reg   <= cfg_data;
                REG_OPEN_LEN:      open_len_reg      <= cfg_data[LEN_BITS-1:0];
                REG_CLOSE_MARKER:  close_marker_reg  <= cfg_data;
                REG_CLOSE_LEN:     close_len_reg     <= cfg_data[LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // A line-ending byte needs room in the output register; others never wait
    assign emit    = in_valid_reg && ((ch_reg == CH_NEWLINE) || last_reg);
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            ch_reg   <= s_ch;
            last_reg <= s_last_in_file;
        end
    end

    always_comb begin
        logic is_nl;
        logic proc;
        logic hit;
        logic found;
        int   p_i;
        int   sl;
        int   ol;
        int   cl;
        int   start;
        int   j;

        is_nl = (ch_reg == CH_NEWLINE);
        sl    = eff_len(single_len_reg, MARKER_BYTES);
        ol    = eff_len(open_len_reg, MARKER_BYTES);
        cl    = eff_len(close_len_reg, MARKER_BYTES);
        p_i   = int'(prefix_pos_reg);
        hit   = 1'b0;
        found = 1'b0;
        start = 0;
        j     = 0;

        in_block_next     = in_block_reg;
        started_next      = started_reg;
        nonblank_next     = nonblank_reg;
        prefix_pos_next   = prefix_pos_reg;
        single_match_next = single_match_reg;
        open_match_next   = open_match_reg;
        tail_next         = tail_reg;
        search_count_next = search_count_reg;
        close_seen_next   = close_seen_reg;
        code_count_next   = code_count_reg;
        other_count_next  = other_count_reg;
        cls_next          = CLS_CODE;

        // Leading blanks are skipped; everything from the first non-blank on is taken
        proc = !is_nl && (nonblank_reg || ((ch_reg != CH_SPACE) && (ch_reg != CH_TAB)));

        if (proc) begin
            nonblank_next = 1'b1;
            if (p_i < sl && ch_reg != marker_byte(single_marker_reg, p_i)) begin
                single_match_next = 1'b0;
            end
            if (p_i < ol && ch_reg != marker_byte(open_marker_reg, p_i)) begin
                open_match_next = 1'b0;
            end
            start = started_reg ? 0 : ol;
            if (p_i >= start) begin
                tail_next = (tail_reg << 8) | TW'(ch_reg);
                if (int'(search_count_reg) < MARKER_BYTES) begin
                    search_count_next = search_count_reg + PW'(1);
                end
                if (cl > 0 && int'(search_count_next) >= cl) begin
                    hit = 1'b1;
                    for (int i = 0; i < MARKER_BYTES; i++) begin
                        if (i < cl) begin
                            j = cl - 1 - i;
                            if (tail_next[8*j +: 8] != marker_byte(close_marker_reg, i)) begin
                                hit = 1'b0;
                            end
                        end
                    end
                    if (hit) begin
                        close_seen_next = 1'b1;
                    end
                end
            end
            if (p_i < MARKER_BYTES) begin
                prefix_pos_next = prefix_pos_reg + PW'(1);
            end
        end

        if (emit) begin
            found = close_seen_next || (cl == 0);
            priority if (started_reg) begin
                cls_next = CLS_BLOCK;
                if (found) begin
                    in_block_next = 1'b0;
                end
            end else if (!nonblank_next) begin
                cls_next = CLS_BLANK;
            end else if (single_match_next && int'(prefix_pos_next) >= sl) begin
                cls_next = CLS_SINGLE;
            end else if (open_match_next && int'(prefix_pos_next) >= ol) begin
                cls_next = CLS_BLOCK;
                if (!found) begin
                    in_block_next = 1'b1;
                end
            end else begin
                cls_next = CLS_CODE;
            end

            if (cls_next == CLS_CODE) begin
                if (code_count_reg != '1) begin
                    code_count_next = code_count_reg + COUNT_BITS'(1);
                end
            end else begin
                if (other_count_reg != '1) begin
                    other_count_next = other_count_reg + COUNT_BITS'(1);
                end
            end
            if (last_reg) begin
                in_block_next = 1'b0;
            end

            // Start the next line
            started_next      = in_block_next;
            nonblank_next     = 1'b0;
            prefix_pos_next   = '0;
            single_match_next = 1'b1;
            open_match_next   = 1'b1;
            tail_next         = '0;
            search_count_next = '0;
            close_seen_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_block_reg     <= 1'b0;
            started_reg      <= 1'b0;
            nonblank_reg     <= 1'b0;
            prefix_pos_reg   <= '0;
            single_match_reg <= 1'b1;
            open_match_reg   <= 1'b1;
            tail_reg         <= '0;
            search_count_reg <= '0;
            close_seen_reg   <= 1'b0;
            code_count_reg   <= '0;
            other_count_reg  <= '0;
        end else if (advance) begin
            in_block_reg     <= in_block_next;
            started_reg      <= started_next;
            nonblank_reg     <= nonblank_next;
            prefix_pos_reg   <= prefix_pos_next;
            single_match_reg <= single_match_next;
            open_match_reg   <= open_match_next;
            tail_reg         <= tail_next;
            search_count_reg <= search_count_next;
            close_seen_reg   <= close_seen_next;
            code_count_reg   <= code_count_next;
            other_count_reg  <= other_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_class_reg <= cls_next;
            out_done_reg  <= last_reg;
            out_code_reg  <= 32'(code_count_next);
            out_other_reg <= 32'(other_count_next);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_line_class  = out_class_reg;
    assign m_file_done   = out_done_reg;
    assign m_code_lines  = out_code_reg;
    assign m_other_lines = out_other_reg;

`ifndef SYNTH
    // Never overwrite a result that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |-> (!out_valid_reg || m_ready))
        else $error("line result overwritten while stalled");

    // A line that began in block mode is always a block comment line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && started_reg) |-> (cls_next == CLS_BLOCK))
        else $error("block-mode line not classed as block comment");

    // File end leaves no block mode behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && last_reg) |=> (!in_block_reg && !started_reg))
        else $error("block mode survived end of file");

    // A counted code line leaves a nonzero code count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && cls_next == CLS_CODE) |=> (code_count_reg != '0))
        else $error("code count did not advance");

    // Bytes that end no line leave both counters alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !emit) |=> ($stable(code_count_reg) && $stable(other_count_reg)))
        else $error("counter moved without a finished line");
`endif

endmodule

`default_nettype wire
